### src/stl_pkg.sv
// stl_pkg: widths, codes and fixed constants of the skewed triangle oscillator
// used by the channel interfaces and the top level; no dependencies
`timescale 1ns / 1ps

package stl_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned KNOB_W     = 10;
  localparam int unsigned PERIOD_W   = 31;
  localparam int unsigned WAVE_W     = 16;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned FS_W       = 30;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned OMAX_W     = 16;
  localparam int unsigned RES_W      = 16;
  localparam int unsigned CFG_DATA_W = 30;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned KNOB_DEADBAND = 10;
  localparam int unsigned KNOB_HYST     = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_KNOB    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE   = 3'd0,
    CFG_SCALE_SHIFT  = 3'd1,
    CFG_OUTPUT_MAX   = 3'd2,
    CFG_UPDATE_RES   = 3'd3,
    CFG_TRIANGLE     = 3'd4
  } cfg_reg_e;

endpackage

### src/stl_item_if.sv
// stl_item_if: command channel carrying one input item (valid/ready)
// depends on stl_pkg for field widths
`timescale 1ns / 1ps

interface stl_item_if import stl_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [KNOB_W-1:0]   freq_knob;
  logic [KNOB_W-1:0]   duty_knob;
  logic [PERIOD_W-1:0] period_word;

  modport source (output valid, output cmd, output freq_knob, output duty_knob,
                  output period_word, input ready);
  modport sink   (input valid, input cmd, input freq_knob, input duty_knob,
                  input period_word, output ready);
endinterface

### src/stl_result_if.sv
// stl_result_if: result channel carrying one oscillator output item (valid/ready)
// depends on stl_pkg for field widths
`timescale 1ns / 1ps

interface stl_result_if import stl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WAVE_W-1:0] wave_out;
  logic              going_up;

  modport source (output valid, output wave_out, output going_up, input ready);
  modport sink   (input valid, input wave_out, input going_up, output ready);
endinterface

### src/skewed_triangle_lfo.sv
// skewed_triangle_lfo: triangle/square oscillator with rise/fall skew
// depends on stl_pkg, stl_item_if, stl_result_if
`timescale 1ns / 1ps
//
// Usage
//   item_i carries commands: tick (moves the phase by one step and reflects at
//   either end), knob update (frequency knob, duty knob, period word) and phase
//   restart. Every command gives exactly one item on result_o: the current
//   output code and the direction flag.
//   cfg_we_i/cfg_idx_i/cfg_data_i write full_scale, scale_shift, output_max,
//   update_resolution and triangle_mode; write them only while no item is open.
// Sequencing
//   One item is worked on at a time; ready is high only between items.
//   tick: S_TICK, S_REFL, then S_OUT, S_SHIFT (arithmetic right shift by scale_shift)
//   and S_DONE to the result register. restart or unused code goes to S_OUT; a knob update
//   without a change goes S_KNOB to S_OUT. A knob update with a change runs the one-bit-per-cycle
//   multiplier and the one-bit-per-cycle divider that runs five divisions in turn, plus a second
//   multiplication when period times duty overflows 31 bits.
// Reset and stall
//   Reset restores the register defaults, clears phase and steps and sets the
//   direction to rising. A finished result waits in the output register while
//   the next item is taken; the block holds before delivering until it is free.

module skewed_triangle_lfo import stl_pkg::*; #(
  parameter int unsigned KNOB_MAX = 1023
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  stl_item_if.sink              item_i,
  stl_result_if.source          result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned KNOB_BITS = $clog2(KNOB_MAX + 1);
  localparam int unsigned KW = (KNOB_BITS > KNOB_W) ? KNOB_BITS : KNOB_W;
  localparam int unsigned PW = PERIOD_W + KW;
  localparam int unsigned CW = $clog2(PW + 1);
  localparam int unsigned SW = PHASE_W + 2;

  localparam logic [KW-1:0]   KnobMaxK  = KW'(KNOB_MAX);
  localparam logic [KW-1:0]   KnobLoK   = KW'(KNOB_DEADBAND);
  localparam logic [KW-1:0]   KnobHiK   = KW'(KNOB_MAX - KNOB_DEADBAND);
  localparam logic [KW:0]     KnobHystK = (KW + 1)'(KNOB_HYST);
  localparam logic [STEP_W-1:0] KnobDivK = STEP_W'(KNOB_MAX);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_TICK  = 11'b000_0000_0010,
    S_REFL  = 11'b000_0000_0100,
    S_KNOB  = 11'b000_0000_1000,
    S_MUL   = 11'b000_0001_0000,
    S_CHK   = 11'b000_0010_0000,
    S_DIV   = 11'b000_0100_0000,
    S_DDONE = 11'b000_1000_0000,
    S_OUT   = 11'b001_0000_0000,
    S_SHIFT = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    DV_KQ   = 3'd0,
    DV_KP   = 3'd1,
    DV_UP   = 3'd2,
    DV_RISE = 3'd3,
    DV_DN   = 3'd4,
    DV_FALL = 3'd5
  } div_op_e;

  state_e state_q, state_d;

  logic [FS_W-1:0]     full_scale_q, full_scale_d;
  logic [SHIFT_W-1:0]  scale_shift_q, scale_shift_d;
  logic [OMAX_W-1:0]   output_max_q, output_max_d;
  logic [RES_W-1:0]    res_q, res_d;
  logic                tri_q, tri_d;

  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic                rising_q, rising_d;
  logic [STEP_W-1:0]   rise_q, rise_d;
  logic [STEP_W-1:0]   fall_q, fall_d;
  logic [PERIOD_W-1:0] held_q, held_d;
  logic [KNOB_W-1:0]   last_freq_q, last_freq_d;
  logic [KNOB_W-1:0]   last_duty_q, last_duty_d;

  logic                out_valid_q, out_valid_d;
  logic [WAVE_W-1:0]   wave_q, wave_d;
  logic                up_q, up_d;

  logic [KNOB_W-1:0]   fk_q, fk_d;
  logic [KNOB_W-1:0]   dk_q, dk_d;
  logic [PERIOD_W-1:0] pw_q, pw_d;
  logic [KW-1:0]       duty_q, duty_d;
  logic [SW-1:0]       sum_q, sum_d;
  logic [PHASE_W-1:0]  sh_q, sh_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [PW-1:0]       acc_q, acc_d;
  logic [PW-1:0]       mcand_q, mcand_d;
  logic [KW-1:0]       mplier_q, mplier_d;
  logic                second_q, second_d;
  logic [PW-1:0]       dnd_q, dnd_d;
  logic [STEP_W-1:0]   dsr_q, dsr_d;
  logic [STEP_W-1:0]   rem_q, rem_d;
  div_op_e             op_q, op_d;
  logic [STEP_W-1:0]   dp_q, dp_d;

  // combinational helpers
  logic [KW-1:0]       fkw, dkw, freq_b, duty_b;
  logic                freq_moved, duty_moved;
  logic [PERIOD_W-1:0] per_next;
  logic [SW-1:0]       fs_ext, two_fs, ps_ext;
  logic [STEP_W:0]     trial, trial_diff;
  logic                trial_ge;
  logic [STEP_W-1:0]   quo, quo_min1, res_div, down_amt;
  logic [PHASE_W-1:0]  omax_ext;

  assign item_i.ready      = (state_q == S_IDLE);
  assign result_o.valid    = out_valid_q;
  assign result_o.wave_out = wave_q;
  assign result_o.going_up = up_q;

  always_comb begin
    fkw    = KW'(fk_q);
    dkw    = KW'(dk_q);
    freq_b = (fkw < KnobLoK) ? '0 : ((fkw > KnobHiK) ? KnobMaxK : fkw);
    duty_b = (dkw < KnobLoK) ? '0 : ((dkw > KnobHiK) ? KnobMaxK : dkw);
    freq_moved = (({1'b0, freq_b} + KnobHystK) < (KW + 1)'(last_freq_q)) ||
                 ({1'b0, freq_b} > ((KW + 1)'(last_freq_q) + KnobHystK));
    duty_moved = (({1'b0, duty_b} + KnobHystK) < (KW + 1)'(last_duty_q)) ||
                 ({1'b0, duty_b} > ((KW + 1)'(last_duty_q) + KnobHystK));
    per_next   = freq_moved ? pw_q : held_q;

    fs_ext = SW'(full_scale_q);
    two_fs = SW'({full_scale_q, 1'b0});
    ps_ext = {{2{phase_q[PHASE_W-1]}}, phase_q};

    trial      = {rem_q, dnd_q[PW-1]};
    trial_diff = trial - {1'b0, dsr_q};
    trial_ge   = (trial >= {1'b0, dsr_q});

    quo      = dnd_q[STEP_W-1:0];
    quo_min1 = (quo == '0) ? STEP_W'(1) : quo;
    res_div  = (res_q == '0) ? STEP_W'(1) : STEP_W'(res_q);
    down_amt = (STEP_W'(held_q) >= dp_q) ? (STEP_W'(held_q) - dp_q) : '0;
    omax_ext = PHASE_W'(output_max_q);
  end

  always_comb begin
    state_d       = state_q;
    full_scale_d  = full_scale_q;
    scale_shift_d = scale_shift_q;
    output_max_d  = output_max_q;
    res_d         = res_q;
    tri_d         = tri_q;
    phase_d       = phase_q;
    rising_d      = rising_q;
    rise_d        = rise_q;
    fall_d        = fall_q;
    held_d        = held_q;
    last_freq_d   = last_freq_q;
    last_duty_d   = last_duty_q;
    out_valid_d   = out_valid_q;
    wave_d        = wave_q;
    up_d          = up_q;
    fk_d          = fk_q;
    dk_d          = dk_q;
    pw_d          = pw_q;
    duty_d        = duty_q;
    sum_d         = sum_q;
    sh_d          = sh_q;
    cnt_d         = cnt_q;
    acc_d         = acc_q;
    mcand_d       = mcand_q;
    mplier_d      = mplier_q;
    second_d      = second_q;
    dnd_d         = dnd_q;
    dsr_d         = dsr_q;
    rem_d         = rem_q;
    op_d          = op_q;
    dp_d          = dp_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FULL_SCALE:  full_scale_d  = cfg_data_i[FS_W-1:0];
        CFG_SCALE_SHIFT: scale_shift_d = cfg_data_i[SHIFT_W-1:0];
        CFG_OUTPUT_MAX:  output_max_d  = cfg_data_i[OMAX_W-1:0];
        CFG_UPDATE_RES:  res_d         = cfg_data_i[RES_W-1:0];
        CFG_TRIANGLE:    tri_d         = cfg_data_i[0];
        default: ;
      endcase
    end

    if (result_o.valid && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (item_i.valid) begin
          fk_d = item_i.freq_knob;
          dk_d = item_i.duty_knob;
          pw_d = item_i.period_word;
          case (item_i.cmd)
            CMD_TICK:    state_d = S_TICK;
            CMD_KNOB:    state_d = S_KNOB;
            CMD_RESTART: begin
              phase_d  = '0;
              rising_d = 1'b1;
              state_d  = S_OUT;
            end
            default:     state_d = S_OUT;
          endcase
        end
      end
      S_TICK: begin
        sum_d   = rising_q ? (ps_ext + SW'(rise_q)) : (ps_ext - SW'(fall_q));
        state_d = S_REFL;
      end
      S_REFL: begin
        if ($signed(sum_q) >= $signed(fs_ext)) begin
          phase_d  = PHASE_W'(two_fs - sum_q);
          rising_d = 1'b0;
        end else if ($signed(sum_q) <= $signed(SW'(0))) begin
          phase_d  = PHASE_W'(SW'(0) - sum_q);
          rising_d = 1'b1;
        end else begin
          phase_d = sum_q[PHASE_W-1:0];
        end
        state_d = S_OUT;
      end
      S_KNOB: begin
        if (freq_moved) begin
          held_d      = pw_q;
          last_freq_d = freq_b[KNOB_W-1:0];
        end
        duty_d = duty_b;
        if (freq_moved || duty_moved) begin
          acc_d    = '0;
          mcand_d  = PW'(per_next);
          mplier_d = duty_b;
          cnt_d    = '0;
          second_d = 1'b0;
          state_d  = S_MUL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MUL: begin
        acc_d    = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
        mcand_d  = {mcand_q[PW-2:0], 1'b0};
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q == CW'(KW - 1)) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cnt_d   = '0;
        rem_d   = '0;
        state_d = S_DIV;
        if (second_q) begin
          dp_d  = acc_q[STEP_W-1:0];
          dnd_d = PW'(acc_q[STEP_W-1:0]);
          dsr_d = res_div;
          op_d  = DV_UP;
        end else if (|acc_q[PW-1:STEP_W]) begin
          dnd_d = PW'(held_q);
          dsr_d = KnobDivK;
          op_d  = DV_KQ;
        end else begin
          dnd_d = acc_q;
          dsr_d = KnobDivK;
          op_d  = DV_KP;
        end
      end
      S_DIV: begin
        rem_d = trial_ge ? trial_diff[STEP_W-1:0] : trial[STEP_W-1:0];
        dnd_d = {dnd_q[PW-2:0], trial_ge};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(PW - 1)) begin
          state_d = S_DDONE;
        end
      end
      S_DDONE: begin
        cnt_d   = '0;
        rem_d   = '0;
        state_d = S_DIV;
        case (op_q)
          DV_KQ: begin
            acc_d    = '0;
            mcand_d  = PW'(quo);
            mplier_d = duty_q;
            second_d = 1'b1;
            state_d  = S_MUL;
          end
          DV_KP: begin
            dp_d  = quo;
            dnd_d = PW'(quo);
            dsr_d = res_div;
            op_d  = DV_UP;
          end
          DV_UP: begin
            dnd_d = PW'(full_scale_q);
            dsr_d = quo_min1;
            op_d  = DV_RISE;
          end
          DV_RISE: begin
            rise_d = quo;
            dnd_d  = PW'(down_amt);
            dsr_d  = res_div;
            op_d   = DV_DN;
          end
          DV_DN: begin
            dnd_d = PW'(full_scale_q);
            dsr_d = quo_min1;
            op_d  = DV_FALL;
          end
          DV_FALL: begin
            fall_d      = quo;
            last_duty_d = duty_q[KNOB_W-1:0];
            state_d     = S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_OUT: begin
        sh_d    = phase_q;
        cnt_d   = CW'(scale_shift_q);
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          sh_d  = {sh_q[PHASE_W-1], sh_q[PHASE_W-1:1]};
          cnt_d = cnt_q - CW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          up_d        = rising_q;
          if (!tri_q) begin
            wave_d = rising_q ? output_max_q : '0;
          end else if (sh_q[PHASE_W-1]) begin
            wave_d = '0;
          end else if (sh_q > omax_ext) begin
            wave_d = output_max_q;
          end else begin
            wave_d = sh_q[WAVE_W-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      full_scale_q  <= FS_W'(1073741823);
      scale_shift_q <= SHIFT_W'(18);
      output_max_q  <= OMAX_W'(4095);
      res_q         <= RES_W'(1000);
      tri_q         <= 1'b1;
      phase_q       <= '0;
      rising_q      <= 1'b1;
      rise_q        <= '0;
      fall_q        <= '0;
      held_q        <= '0;
      last_freq_q   <= '0;
      last_duty_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      full_scale_q  <= full_scale_d;
      scale_shift_q <= scale_shift_d;
      output_max_q  <= output_max_d;
      res_q         <= res_d;
      tri_q         <= tri_d;
      phase_q       <= phase_d;
      rising_q      <= rising_d;
      rise_q        <= rise_d;
      fall_q        <= fall_d;
      held_q        <= held_d;
      last_freq_q   <= last_freq_d;
      last_duty_q   <= last_duty_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wave_q   <= wave_d;
    up_q     <= up_d;
    fk_q     <= fk_d;
    dk_q     <= dk_d;
    pw_q     <= pw_d;
    duty_q   <= duty_d;
    sum_q    <= sum_d;
    sh_q     <= sh_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    second_q <= second_d;
    dnd_q    <= dnd_d;
    dsr_q    <= dsr_d;
    rem_q    <= rem_d;
    op_q     <= op_d;
    dp_q     <= dp_d;
  end

endmodule
